FILE: design/point_in_polygon_crossing_test_defines.svh
// Assertion macros for the point-in-polygon crossing test block.
`ifndef POINT_IN_POLYGON_CROSSING_TEST_DEFINES_SVH
`define POINT_IN_POLYGON_CROSSING_TEST_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PIPCT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pipct check failed");

// Next-cycle implication, disabled during reset.
`define PIPCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pipct check failed");

`endif

FILE: design/pipct_pkg.sv
// Types, constants and helper functions shared by the crossing test block.
package pipct_pkg;

  localparam int COORD_BITS = 32;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int WIDE_BITS  = 68;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
  localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

  localparam logic CFG_QUERY_X = 1'b0;
  localparam logic CFG_QUERY_Y = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [WIDE_BITS-1:0]  wide_t;

  typedef struct packed {
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic               last_vertex;
  } vertex_word_t;

  typedef struct packed {
    logic inside_res;
    logic overflow;
  } result_word_t;

  // One edge, already classified, with the four cross product operands.
  typedef struct packed {
    diff_t dxe;
    diff_t dyq;
    diff_t dye;
    diff_t dxq;
    logic  straddle;
    logic  rises;
    logic  last;
  } edge_word_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic coord_t coord_of(logic [31:0] v);
    coord_of = v[COORD_BITS-1:0];
  endfunction

  function automatic edge_word_t make_edge(coord_t x1, coord_t y1, coord_t x2, coord_t y2,
                                           coord_t qx, coord_t qy, logic last);
    edge_word_t e;
    e.dxe      = diff_t'(x2) - diff_t'(x1);
    e.dyq      = diff_t'(qy) - diff_t'(y1);
    e.dye      = diff_t'(y2) - diff_t'(y1);
    e.dxq      = diff_t'(qx) - diff_t'(x1);
    e.straddle = (y1 > qy) != (y2 > qy);
    e.rises    = y2 > y1;
    e.last     = last;
    make_edge  = e;
  endfunction

  // True when the value lies in the signed 64-bit range.
  function automatic logic fits64(wide_t v);
    fits64 = (v[WIDE_BITS-1:63] == '0) || (v[WIDE_BITS-1:63] == '1);
  endfunction

endpackage

FILE: design/pipct_front.sv
// Front end: takes vertex words, keeps first/previous vertex, emits edge words.
module pipct_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [31:0]           cfg_data,
  input  logic                  vertex_valid,
  output logic                  vertex_stall,
  input  pipct_pkg::vertex_word_t vertex,
  input  pipct_pkg::q_status_t  q_status,
  output logic                  push,
  output pipct_pkg::edge_word_t push_word
);
  import pipct_pkg::*;

  coord_t query_x, query_y;
  coord_t first_x, first_y, prev_x, prev_y;
  logic   have_prev, pend_close;
  logic   take;
  coord_t cur_x, cur_y;
  edge_word_t in_edge, close_edge, solo_edge;

  assign cur_x = coord_of(vertex.vertex_x);
  assign cur_y = coord_of(vertex.vertex_y);

  // closing edge gets its own cycle on the queue
  assign vertex_stall = pend_close || q_status.full;
  assign take         = vertex_valid && !vertex_stall;

  assign in_edge    = make_edge(prev_x, prev_y, cur_x, cur_y, query_x, query_y, 1'b0);
  assign close_edge = make_edge(prev_x, prev_y, first_x, first_y, query_x, query_y, 1'b1);
  // single-vertex polygon: closing edge onto itself never straddles
  assign solo_edge  = make_edge(cur_x, cur_y, cur_x, cur_y, query_x, query_y, 1'b1);

  always_comb begin
    push      = 1'b0;
    push_word = in_edge;
    if (pend_close) begin
      push      = !q_status.full;
      push_word = close_edge;
    end else if (take) begin
      if (have_prev) begin
        push      = in_edge.straddle;
        push_word = in_edge;
      end else if (vertex.last_vertex) begin
        push      = 1'b1;
        push_word = solo_edge;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      query_x    <= '0;
      query_y    <= '0;
      have_prev  <= 1'b0;
      pend_close <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_QUERY_X: query_x <= coord_of(cfg_data);
          CFG_QUERY_Y: query_y <= coord_of(cfg_data);
          default: ;
        endcase
      end
      if (pend_close) begin
        if (!q_status.full) begin
          pend_close <= 1'b0;
          have_prev  <= 1'b0;
        end
      end else if (take) begin
        if (!have_prev) begin
          first_x <= cur_x;
          first_y <= cur_y;
        end
        prev_x <= cur_x;
        prev_y <= cur_y;
        if (vertex.last_vertex) begin
          pend_close <= have_prev;
          have_prev  <= 1'b0;
          if (have_prev) have_prev <= 1'b1;
        end else begin
          have_prev <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: design/pipct_queue.sv
// Short FIFO of edge words between front and back.
module pipct_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  pipct_pkg::edge_word_t push_word,
  input  logic                  pop,
  output pipct_pkg::edge_word_t head,
  output pipct_pkg::q_status_t  status
);
  import pipct_pkg::*;

  edge_word_t              slots [Q_DEPTH];
  logic [Q_PTR_BITS-1:0]   wr_ptr, rd_ptr;
  logic [Q_CNT_BITS-1:0]   count;
  logic                    do_push, do_pop;

  assign status.full  = count == Q_CNT_BITS'(Q_DEPTH);
  assign status.empty = count == '0;
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: design/pipct_back.sv
// Back end: cross products, overflow check, parity and the result register.
module pipct_back (
  input  logic                    clk,
  input  logic                    rst,
  input  pipct_pkg::edge_word_t   head,
  input  pipct_pkg::q_status_t    q_status,
  output logic                    pop,
  output logic                    result_valid,
  input  logic                    result_stall,
  output pipct_pkg::result_word_t result
);
  import pipct_pkg::*;

  logic  m_valid, m_straddle, m_rises, m_last;
  prod_t m_a, m_b;
  logic  parity, overflow_seen;
  logic  out_free, m_go, m_load;
  wide_t a_w, b_w, d_w;
  logic  edge_ovf, neg, pos, toggle, parity_next, ovf_next;

  assign out_free = !result_valid || !result_stall;
  assign m_go     = m_valid && (!m_last || out_free);
  assign m_load   = !m_valid || m_go;
  assign pop      = m_load && !q_status.empty;

  assign a_w      = wide_t'(m_a);
  assign b_w      = wide_t'(m_b);
  assign d_w      = a_w - b_w;
  assign edge_ovf = !fits64(a_w) || !fits64(b_w) || !fits64(d_w);
  assign neg      = d_w[WIDE_BITS-1];
  assign pos      = !neg && (d_w != '0);
  assign toggle   = m_straddle && !edge_ovf && ((m_rises && pos) || (!m_rises && neg));
  assign parity_next = parity ^ toggle;
  assign ovf_next    = overflow_seen || (m_straddle && edge_ovf);

  // multiply stage
  always_ff @(posedge clk) begin
    if (pop) begin
      m_a        <= prod_t'(head.dxe) * prod_t'(head.dyq);
      m_b        <= prod_t'(head.dye) * prod_t'(head.dxq);
      m_straddle <= head.straddle;
      m_rises    <= head.rises;
      m_last     <= head.last;
    end
  end

  always_ff @(posedge clk) begin
    if (m_go && m_last) begin
      result.inside_res <= parity_next && !ovf_next;
      result.overflow   <= ovf_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid       <= 1'b0;
      parity        <= 1'b0;
      overflow_seen <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      if (m_load) m_valid <= pop;
      if (m_go) begin
        if (m_last) begin
          parity        <= 1'b0;
          overflow_seen <= 1'b0;
        end else begin
          parity        <= parity_next;
          overflow_seen <= ovf_next;
        end
      end
      if (m_go && m_last)  result_valid <= 1'b1;
      else if (out_free)   result_valid <= 1'b0;
    end
  end

endmodule

FILE: design/point_in_polygon_crossing_test.sv
// Top level of the point-in-polygon crossing-number test.
//
// Vertices of one closed polygon stream in on the vertex channel, one word per
// vertex; last_vertex marks the final one and the polygon closes back to its
// first vertex. query_x (index 0) and query_y (index 1) are to be written on
// the config port while the block is idle; the block does not enforce this.
// One result word (inside_res, overflow) leaves on the result channel per
// polygon. Rate: one vertex per cycle while vertex_stall is low; the last
// vertex of a polygon with two or more vertices is followed by a stall, since
// the front end pushes the closing edge into the edge queue on a cycle of its
// own. With an empty edge queue and a free output register, the closing edge
// enters the queue, the 33x33 multiply stage loads, then the 64-bit range
// check and parity update load the output register and the result word is
// valid; a single-vertex polygon queues its closing edge in the cycle the
// vertex is taken. The four-entry edge queue lets the front keep taking
// vertices while a result waits on result_stall.
module point_in_polygon_crossing_test (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [31:0]             cfg_data,
  input  logic                    vertex_valid,
  output logic                    vertex_stall,
  input  pipct_pkg::vertex_word_t vertex,
  output logic                    result_valid,
  input  logic                    result_stall,
  output pipct_pkg::result_word_t result
);
  import pipct_pkg::*;

  // front -> queue
  logic       push;
  edge_word_t push_word;
  // queue -> back
  edge_word_t head;
  q_status_t  q_status;
  logic       pop;

  pipct_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .vertex_valid (vertex_valid),
    .vertex_stall (vertex_stall),
    .vertex       (vertex),
    .q_status     (q_status),
    .push         (push),
    .push_word    (push_word)
  );

  pipct_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  pipct_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_status     (q_status),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

FILE: design/pipct_checker.sv
// Port-level checks for the crossing test block, bound to the top level.
`include "point_in_polygon_crossing_test_defines.svh"

module pipct_checker (
  input logic                    clk,
  input logic                    rst,
  input logic                    result_valid,
  input logic                    result_stall,
  input pipct_pkg::result_word_t result
);
  import pipct_pkg::*;

  `PIPCT_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && result_stall, result_valid && $stable(result))
  `PIPCT_ASSERT_NOW(a_inside_excl_ovf, clk, rst, result_valid, !(result.inside_res && result.overflow))
  `PIPCT_ASSERT_NOW(a_quiet_after_reset, clk, rst, $past(rst), !result_valid)

endmodule

bind point_in_polygon_crossing_test pipct_checker u_pipct_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
